// ===== rtl/dbsv_pkg.sv =====
package dbsv_pkg;

	// Payload of the character channel.
	typedef struct packed {
		logic       action;
		logic [7:0] character;
	} char_word_t;

	// Payload of the result channel.
	typedef struct packed {
		logic [1:0] verdict;
		logic       final_res;
	} result_word_t;

	// Payload of the configuration channel.
	typedef struct packed {
		logic single_mode;
	} cfg_word_t;

	// Values of the action field.
	localparam logic ACTION_CHAR = 1'b0;
	localparam logic ACTION_END  = 1'b1;

	// Verdict codes.
	localparam logic [1:0] VERDICT_PENDING = 2'd0;
	localparam logic [1:0] VERDICT_VALID   = 2'd1;
	localparam logic [1:0] VERDICT_INVALID = 2'd2;

	// Character classes worked out by the front part.
	typedef enum logic [2:0] {
		CLS_BASIC        = 3'd0,
		CLS_VARIANT      = 3'd1,
		CLS_ARRAY        = 3'd2,
		CLS_DICT_OPEN    = 3'd3,
		CLS_DICT_CLOSE   = 3'd4,
		CLS_STRUCT_OPEN  = 3'd5,
		CLS_STRUCT_CLOSE = 3'd6,
		CLS_BAD          = 3'd7
	} char_class_t;

	// One classified word as it waits in the queue.
	typedef struct packed {
		logic        is_end;
		char_class_t cls;
	} item_t;

	// Progress of an open frame. A struct moves from open to one once it holds
	// a type; a dict entry moves from open (needs key) to one (needs value) to
	// two (needs the closing brace).
	localparam logic [1:0] PROG_OPEN = 2'd0;
	localparam logic [1:0] PROG_ONE  = 2'd1;
	localparam logic [1:0] PROG_TWO  = 2'd2;

	// One stack frame. The pending-array count of the enclosing level is not
	// kept: a frame is only ever closed as a complete type, which clears it.
	typedef struct packed {
		logic       dict;
		logic [1:0] prog;
	} frame_t;

endpackage

// ===== rtl/dbsv_chan_if.sv =====
interface dbsv_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/dbus_signature_validator.sv =====
// Checks a D-Bus type signature against the type grammar, one character word
// at a time, and answers every word with one result word: on a character the
// verdict is "no error so far" or "invalid", on an end word (action 1) it is
// "valid" or "invalid" with final_res set, and the parse state is cleared for
// the next signature. The single_mode register demands exactly one complete
// top-level type and may only be written while no words are in flight. A new
// character is taken every cycle while the queue has room; the sustained rate
// is one word per cycle while the result channel is not stalled, set by the
// back end updating the stack top and counters as each word is taken. The
// result of a word is offered on the result channel once the word has passed
// a two-entry queue and a result register, so either side may stall without
// stopping the other at once. Open frames live in a RAM of MAX_NESTING
// entries with the top frame held in registers; the RAM needs no clearing
// after reset, so words are accepted as soon as reset is released.
module dbus_signature_validator import dbsv_pkg::*; #(
	parameter int MAX_NESTING   = 32,
	parameter int MAX_ARRAY_RUN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	dbsv_chan_if.sink   cfg,
	dbsv_chan_if.sink   chars,
	dbsv_chan_if.source results
);

	logic  single_q;
	logic  push_valid;
	item_t push_item;
	logic  push_ready;
	logic  pop_valid;
	item_t pop_item;
	logic  pop_ready;

	// Configuration register; writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_q <= 1'b0;
		end else if (cfg.valid) begin
			single_q <= cfg.data.single_mode;
		end
	end

	// Front end: classify incoming characters.
	dbsv_front u_front (
		.chars      (chars),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	// Short queue between the two halves.
	dbsv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// Back end: run the grammar against the frame stack.
	dbsv_back #(
		.MAX_NESTING   (MAX_NESTING),
		.MAX_ARRAY_RUN (MAX_ARRAY_RUN)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.single_mode (single_q),
		.pop_valid   (pop_valid),
		.pop_item    (pop_item),
		.pop_ready   (pop_ready),
		.results     (results)
	);

endmodule

// ===== rtl/dbsv_ram.sv =====
module dbsv_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 32,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/dbsv_front.sv =====
module dbsv_front import dbsv_pkg::*; (
	dbsv_chan_if.sink chars,
	output logic      push_valid,
	output item_t     push_item,
	input  logic      push_ready
);

	// Bracket and array characters.
	localparam logic [7:0] CH_ARRAY        = "a";
	localparam logic [7:0] CH_VARIANT      = "v";
	localparam logic [7:0] CH_DICT_OPEN    = "{";
	localparam logic [7:0] CH_DICT_CLOSE   = "}";
	localparam logic [7:0] CH_STRUCT_OPEN  = "(";
	localparam logic [7:0] CH_STRUCT_CLOSE = ")";

	char_class_t cls;

	// Sort the byte into its grammar class; a zero byte is simply bad.
	always_comb begin
		unique case (chars.data.character)
			"s", "o", "g", "y", "b", "n", "q",
			"i", "u", "x", "t", "d", "h": cls = CLS_BASIC;
			CH_VARIANT:                   cls = CLS_VARIANT;
			CH_ARRAY:                     cls = CLS_ARRAY;
			CH_DICT_OPEN:                 cls = CLS_DICT_OPEN;
			CH_DICT_CLOSE:                cls = CLS_DICT_CLOSE;
			CH_STRUCT_OPEN:               cls = CLS_STRUCT_OPEN;
			CH_STRUCT_CLOSE:              cls = CLS_STRUCT_CLOSE;
			default:                      cls = CLS_BAD;
		endcase
	end

	// Words go straight into the queue whenever it has room.
	assign push_valid       = chars.valid;
	assign push_item.is_end = (chars.data.action == ACTION_END);
	assign push_item.cls    = cls;
	assign chars.ready      = push_ready;

endmodule

// ===== rtl/dbsv_queue.sv =====
module dbsv_queue import dbsv_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push_valid,
	input  item_t push_item,
	output logic  push_ready,
	output logic  pop_valid,
	output item_t pop_item,
	input  logic  pop_ready
);

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Two-entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ===== rtl/dbsv_back.sv =====
module dbsv_back import dbsv_pkg::*; #(
	parameter int MAX_NESTING   = 32,
	parameter int MAX_ARRAY_RUN = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        single_mode,
	input  logic        pop_valid,
	input  item_t       pop_item,
	output logic        pop_ready,
	dbsv_chan_if.source results
);

	localparam int DEPTH_W = $clog2(MAX_NESTING + 1);
	localparam int ADDR_W  = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
	localparam int PEND_W  = $clog2(MAX_ARRAY_RUN + 1);

	// Parse state.
	logic [DEPTH_W-1:0] depth_q, depth_d;
	logic [PEND_W-1:0]  pend_q, pend_d;
	logic               done_q, done_d;
	logic               err_q, err_d;
	frame_t             top_q, top_d;

	// Bypass for the frame just pushed below the new top.
	logic               byp_q;
	frame_t             byp_frame_q;

	// Stack memory and its ports.
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ADDR_W-1:0]  ram_raddr;
	frame_t             ram_rdata;
	frame_t             below;
	logic [DEPTH_W-1:0] rd_depth;

	// Result register.
	logic               out_valid_q;
	result_word_t       out_word_q;
	result_word_t       out_word_d;

	logic fire;
	logic fail;
	logic do_push;
	logic push_dict;
	logic do_pop;
	logic do_complete;
	logic in_dict;
	logic at_limit;
	logic end_ok;

	assign pop_ready = !out_valid_q || results.ready;
	assign fire      = pop_valid && pop_ready;
	assign below     = byp_q ? byp_frame_q : ram_rdata;
	assign in_dict   = (depth_q != '0) && top_q.dict;
	assign at_limit  = (depth_q == DEPTH_W'(MAX_NESTING));
	assign end_ok    = !err_q && (depth_q == '0) && (pend_q == '0) && (!single_mode || done_q);

	// Grammar step: decide what the word does to the stack.
	always_comb begin
		fail        = 1'b0;
		do_push     = 1'b0;
		push_dict   = 1'b0;
		do_pop      = 1'b0;
		do_complete = 1'b0;
		top_d       = top_q;
		pend_d      = pend_q;
		if (!pop_item.is_end && !err_q) begin
			if (single_mode && done_q) begin
				fail = 1'b1;
			end else if (in_dict && top_q.prog == PROG_OPEN) begin
				if (pop_item.cls == CLS_BASIC) begin
					top_d.prog = PROG_ONE;
				end else begin
					fail = 1'b1;
				end
			end else if (in_dict && top_q.prog != PROG_ONE) begin
				if (pop_item.cls == CLS_DICT_CLOSE) begin
					do_pop = 1'b1;
				end else begin
					fail = 1'b1;
				end
			end else begin
				unique case (pop_item.cls)
					CLS_BASIC, CLS_VARIANT: begin
						do_complete = 1'b1;
					end
					CLS_ARRAY: begin
						if (pend_q == PEND_W'(MAX_ARRAY_RUN)) begin
							fail = 1'b1;
						end else begin
							pend_d = pend_q + 1'b1;
						end
					end
					CLS_DICT_OPEN: begin
						if (pend_q == '0 || at_limit) begin
							fail = 1'b1;
						end else begin
							do_push   = 1'b1;
							push_dict = 1'b1;
						end
					end
					CLS_STRUCT_OPEN: begin
						if (at_limit) begin
							fail = 1'b1;
						end else begin
							do_push = 1'b1;
						end
					end
					CLS_STRUCT_CLOSE: begin
						if (depth_q == '0 || in_dict || top_q.prog == PROG_OPEN ||
							pend_q != '0) begin
							fail = 1'b1;
						end else begin
							do_pop = 1'b1;
						end
					end
					CLS_DICT_CLOSE, CLS_BAD: begin
						fail = 1'b1;
					end
				endcase
			end
		end

		// Apply the stack moves; a closed frame always completes a type.
		depth_d = depth_q;
		done_d  = done_q;
		err_d   = err_q || fail;
		if (pop_item.is_end) begin
			depth_d = '0;
			pend_d  = '0;
			done_d  = 1'b0;
			err_d   = 1'b0;
		end else if (do_push) begin
			depth_d   = depth_q + 1'b1;
			pend_d    = '0;
			top_d     = '{dict: push_dict, prog: PROG_OPEN};
		end else if (do_pop) begin
			depth_d = depth_q - 1'b1;
			pend_d  = '0;
			if (depth_q == DEPTH_W'(1)) begin
				done_d = 1'b1;
			end else begin
				top_d      = below;
				top_d.prog = below.dict ? PROG_TWO : PROG_ONE;
			end
		end else if (do_complete) begin
			pend_d = '0;
			if (depth_q == '0) begin
				done_d = 1'b1;
			end else begin
				top_d.prog = top_q.dict ? PROG_TWO : PROG_ONE;
			end
		end
	end

	// Result word for this step.
	always_comb begin
		if (pop_item.is_end) begin
			out_word_d.verdict   = end_ok ? VERDICT_VALID : VERDICT_INVALID;
			out_word_d.final_res = 1'b1;
		end else begin
			out_word_d.verdict   = err_d ? VERDICT_INVALID : VERDICT_PENDING;
			out_word_d.final_res = 1'b0;
		end
	end

	// Stack spill on push; the read side always looks one below the next top.
	assign ram_we    = fire && do_push && (depth_q != '0);
	assign ram_waddr = ADDR_W'(depth_q - 1'b1);
	assign rd_depth  = fire ? depth_d : depth_q;
	assign ram_raddr = (rd_depth >= DEPTH_W'(2)) ? ADDR_W'(rd_depth - DEPTH_W'(2)) : '0;

	dbsv_ram #(
		.WIDTH ($bits(frame_t)),
		.DEPTH (MAX_NESTING)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (top_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q     <= '0;
			pend_q      <= '0;
			done_q      <= 1'b0;
			err_q       <= 1'b0;
			byp_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			byp_q <= fire && do_push;
			if (fire) begin
				depth_q <= depth_d;
				pend_q  <= pend_d;
				done_q  <= done_d;
				err_q   <= err_d;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (fire) begin
			top_q       <= top_d;
			byp_frame_q <= top_q;
			out_word_q  <= out_word_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_word_q;

endmodule
